// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the parser top; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define AST_PROP(lbl, clk, rst_n, prop, msg)
`define AST_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/fcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbp_pkg
// Types, character codes and helpers of the framed command byte parser.
// ----------------------------------------------------------------------------
package fcbp_pkg;

  // Frame framing characters
  localparam logic [7:0] CH_START  = 8'h3C;  // '<'
  localparam logic [7:0] CH_END    = 8'h3E;  // '>'

  // Frame types
  localparam logic [7:0] TYPE_MOVE   = 8'h4D;  // 'M'
  localparam logic [7:0] TYPE_SHOW   = 8'h52;  // 'R'
  localparam logic [7:0] TYPE_REVOLV = 8'h47;  // 'G'

  // Digits
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'

  // Direction letters
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_L_UP = 8'h4C;
  localparam logic [7:0] CH_L_LO = 8'h6C;
  localparam logic [7:0] CH_B_UP = 8'h42;
  localparam logic [7:0] CH_B_LO = 8'h62;
  localparam logic [7:0] CH_O_UP = 8'h4F;
  localparam logic [7:0] CH_O_LO = 8'h6F;

  typedef enum logic [1:0] {
    PH_WAIT_START = 2'd0,
    PH_WAIT_TYPE  = 2'd1,
    PH_PAYLOAD    = 2'd2
  } frame_phase_t;

  typedef enum logic [1:0] {
    SP_WAIT_DIR   = 2'd0,
    SP_WAIT_DIGIT = 2'd1,
    SP_COMPLETE   = 2'd2
  } step_phase_t;

  typedef enum logic [1:0] {
    RK_MOVE    = 2'd0,
    RK_SHOW    = 2'd1,
    RK_REVOLVE = 2'd2
  } report_kind_t;

  typedef enum logic [2:0] {
    DIR_NONE    = 3'd0,
    DIR_FORWARD = 3'd1,
    DIR_RIGHT   = 3'd2,
    DIR_LEFT    = 3'd3,
    DIR_BACK    = 3'd4,
    DIR_OVER    = 3'd5
  } direction_t;

  // Map a direction letter (either case) to its code
  function automatic direction_t dir_code(input logic [7:0] c);
    direction_t d;
    case (c) inside
      CH_F_UP, CH_F_LO: d = DIR_FORWARD;
      CH_R_UP, CH_R_LO: d = DIR_RIGHT;
      CH_L_UP, CH_L_LO: d = DIR_LEFT;
      CH_B_UP, CH_B_LO: d = DIR_BACK;
      CH_O_UP, CH_O_LO: d = DIR_OVER;
      default:          d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/fcbp_in_if.sv =====
// ----------------------------------------------------------------------------
// fcbp_in_if
// Received-byte channel: valid/ready handshake with byte and store status.
// ----------------------------------------------------------------------------
interface fcbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       step_store_full;

  modport source (output valid, output rx_byte, output step_store_full, input ready);
  modport sink   (input valid, input rx_byte, input step_store_full, output ready);
endinterface

// ===== rtl/fcbp_out_if.sv =====
// ----------------------------------------------------------------------------
// fcbp_out_if
// Report channel: valid/ready handshake with one parsed report.
// ----------------------------------------------------------------------------
interface fcbp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] report_kind;
  logic [2:0] direction;
  logic [7:0] step_count;
  logic [7:0] payload_value;

  modport source (output valid, output report_kind, output direction,
                  output step_count, output payload_value, input ready);
  modport sink   (input valid, input report_kind, input direction,
                  input step_count, input payload_value, output ready);
endinterface

// ===== rtl/framed_command_byte_parser_top.sv =====
// ----------------------------------------------------------------------------
// framed_command_byte_parser_top
// Parses '<' type payload '>' frames from a byte stream into move, show and
// revolve reports.
//
// Usage:
//   in_ch  : one received byte per transaction, with the current status of
//            the external step store (step_store_full).
//   out_ch : one report per transaction; a frame yields at most one report,
//            issued when its closing '>' is processed.
//   Report path: the '>' byte lands in the input register, and the parse
//            stage then loads the report register that drives out_ch.
//   Throughput: one byte per cycle while out_ch accepts reports; set by the
//            single parse stage that updates the frame and step state in one pass.
//   Reset (rst_n low, synchronous): frame and step state return to idle,
//            both pipeline registers empty; payload byte holders keep junk
//            until written by a frame.
//   Stall: while a report waits on out_ch, the parse stage holds; the input
//            register takes one more byte if it is empty, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module framed_command_byte_parser_top #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  fcbp_in_if.sink      in_ch,
  fcbp_out_if.source   out_ch
);
  import fcbp_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_full_r;

  // Frame and step state
  frame_phase_t     frame_phase_r, frame_phase_nxt;
  logic [7:0]       frame_type_r, frame_type_nxt;
  logic [CNT_W-1:0] payload_count_r, payload_count_nxt;
  logic [7:0]       first_payload_r, first_payload_nxt;
  logic [7:0]       second_payload_r, second_payload_nxt;
  logic [7:0]       last_payload_r, last_payload_nxt;
  direction_t       pend_dir_r, pend_dir_nxt;
  logic [7:0]       pend_steps_r, pend_steps_nxt;
  step_phase_t      step_phase_r, step_phase_nxt;

  // Report register
  logic         out_valid_r;
  report_kind_t out_kind_r, out_kind_nxt;
  direction_t   out_dir_r, out_dir_nxt;
  logic [7:0]   out_steps_r, out_steps_nxt;
  logic [7:0]   out_value_r, out_value_nxt;
  logic         out_load;

  logic       advance;   // parse stage may consume the input register
  logic       in_fire;
  logic       do_parse;
  direction_t first_dir;

  // Advance whenever the report register is empty or being drained
  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign do_parse = in_v_r && advance;
  assign first_dir = dir_code(first_payload_r);

  // --------------------------------------------------------------------------
  // Input register: hold the byte until the parse stage takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.rx_byte;
      in_full_r <= in_ch.step_store_full;
    end
  end

  // --------------------------------------------------------------------------
  // Parse stage: frame state machine plus step accumulation
  // --------------------------------------------------------------------------
  always_comb begin
    frame_phase_nxt    = frame_phase_r;
    frame_type_nxt     = frame_type_r;
    payload_count_nxt  = payload_count_r;
    first_payload_nxt  = first_payload_r;
    second_payload_nxt = second_payload_r;
    last_payload_nxt   = last_payload_r;
    pend_dir_nxt       = pend_dir_r;
    pend_steps_nxt     = pend_steps_r;
    step_phase_nxt     = step_phase_r;
    out_load           = 1'b0;
    out_kind_nxt       = RK_MOVE;
    out_dir_nxt        = DIR_NONE;
    out_steps_nxt      = 8'd0;
    out_value_nxt      = 8'd0;

    if (do_parse) begin
      unique case (frame_phase_r)
        PH_WAIT_TYPE: begin
          // Any byte is the type, framing characters included
          frame_type_nxt    = in_byte_r;
          frame_phase_nxt   = PH_PAYLOAD;
          payload_count_nxt = '0;
        end
        PH_PAYLOAD: begin
          if (in_byte_r != CH_END) begin
            if (payload_count_r < CNT_LIMIT) begin
              if (payload_count_r == '0) begin
                first_payload_nxt = in_byte_r;
              end else if (payload_count_r == CNT_ONE) begin
                second_payload_nxt = in_byte_r;
              end
              last_payload_nxt  = in_byte_r;
              payload_count_nxt = payload_count_r + CNT_ONE;
            end else begin
              // Overflow: drop the frame
              frame_phase_nxt   = PH_WAIT_START;
              payload_count_nxt = '0;
              frame_type_nxt    = 8'd0;
            end
          end else begin
            if (frame_type_r == TYPE_MOVE) begin
              if (payload_count_r == CNT_TWO) begin
                // Direction and digit together: overwrite both halves
                pend_dir_nxt   = first_dir;
                pend_steps_nxt = second_payload_r - CH_ZERO;
                if (pend_dir_nxt != DIR_NONE && pend_steps_nxt != 8'd0) begin
                  step_phase_nxt = SP_COMPLETE;
                end
              end else if (payload_count_r == CNT_ONE) begin
                // Single half: accumulate with what is pending
                if (first_dir != DIR_NONE) begin
                  pend_dir_nxt   = first_dir;
                  step_phase_nxt = SP_WAIT_DIGIT;
                end else if (first_payload_r >= CH_ZERO && first_payload_r <= CH_SEVEN) begin
                  pend_steps_nxt = first_payload_r - CH_ZERO;
                  if (pend_dir_r != DIR_NONE) begin
                    step_phase_nxt = SP_COMPLETE;
                  end
                end
                if (pend_dir_nxt != DIR_NONE && pend_steps_nxt != 8'd0) begin
                  step_phase_nxt = SP_COMPLETE;
                end
              end
              // Push a complete step only while the store has room
              if (step_phase_nxt == SP_COMPLETE && !in_full_r) begin
                out_load       = 1'b1;
                out_kind_nxt   = RK_MOVE;
                out_dir_nxt    = pend_dir_nxt;
                out_steps_nxt  = pend_steps_nxt;
                pend_dir_nxt   = DIR_NONE;
                pend_steps_nxt = 8'd0;
                step_phase_nxt = SP_WAIT_DIR;
              end
            end else if (frame_type_r == TYPE_SHOW) begin
              if (payload_count_r != '0) begin
                out_load      = 1'b1;
                out_kind_nxt  = RK_SHOW;
                out_value_nxt = last_payload_r;
              end
            end else if (frame_type_r == TYPE_REVOLV) begin
              if (payload_count_r != '0) begin
                out_load      = 1'b1;
                out_kind_nxt  = RK_REVOLVE;
                out_value_nxt = last_payload_r - CH_ZERO;
              end
            end
            // Close the frame
            frame_phase_nxt   = PH_WAIT_START;
            payload_count_nxt = '0;
            frame_type_nxt    = 8'd0;
          end
        end
        default: begin
          // Wait for the start marker
          if (in_byte_r == CH_START) begin
            frame_phase_nxt   = PH_WAIT_TYPE;
            payload_count_nxt = '0;
            frame_type_nxt    = 8'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_phase_r   <= PH_WAIT_START;
      frame_type_r    <= 8'd0;
      payload_count_r <= '0;
      pend_dir_r      <= DIR_NONE;
      pend_steps_r    <= 8'd0;
      step_phase_r    <= SP_WAIT_DIR;
    end else begin
      frame_phase_r   <= frame_phase_nxt;
      frame_type_r    <= frame_type_nxt;
      payload_count_r <= payload_count_nxt;
      pend_dir_r      <= pend_dir_nxt;
      pend_steps_r    <= pend_steps_nxt;
      step_phase_r    <= step_phase_nxt;
    end
  end

  // Payload byte holders: read only after being written in the same frame
  always_ff @(posedge clk) begin
    first_payload_r  <= first_payload_nxt;
    second_payload_r <= second_payload_nxt;
    last_payload_r   <= last_payload_nxt;
  end

  // --------------------------------------------------------------------------
  // Report register: load on a report, drop once the sink takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_dir_r   <= out_dir_nxt;
      out_steps_r <= out_steps_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.report_kind   = out_kind_r;
  assign out_ch.direction     = out_dir_r;
  assign out_ch.step_count    = out_steps_r;
  assign out_ch.payload_value = out_value_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AST_NEVER(a_count_range, clk, rst_n, payload_count_r > CNT_LIMIT,
             "payload count beyond limit")
  `AST_PROP(a_load_on_end, clk, rst_n,
            out_load |-> (in_byte_r == CH_END && frame_phase_r == PH_PAYLOAD),
            "report loaded without a closing marker")
  `AST_PROP(a_move_clears, clk, rst_n,
            (out_load && out_kind_nxt == RK_MOVE) |=>
              (step_phase_r == SP_WAIT_DIR && pend_dir_r == DIR_NONE),
            "pending step not cleared after push")
  `AST_PROP(a_report_fields, clk, rst_n,
            (out_valid_r && out_kind_r != RK_MOVE) |->
              (out_dir_r == DIR_NONE && out_steps_r == 8'd0),
            "show or revolve report carries step fields")
  `AST_PROP(a_ready_stall, clk, rst_n,
            !in_ch.ready |-> (in_v_r && out_valid_r && !out_ch.ready),
            "input stalled without a held report")

endmodule
